@@ rtl/core/sbs_pkg.sv @@
// shared constants, register indexes and helpers for the background subtractor
// no dependencies
`timescale 1ns / 1ps

package sbs_pkg;

   localparam int COORD_W    = 7;
   localparam int PIX_W      = 8;
   localparam int RAND_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CRD_W      = 11;

   // remainder unit retires this many quotient bits per cycle
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = RAND_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

   localparam logic [CSR_IDX_W-1:0] REG_MATCH_RADIUS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_MATCHES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UPDATE_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD_RATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_SLOTS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

   localparam logic [7:0]  RST_MATCH_RADIUS  = 8'd20;
   localparam logic [5:0]  RST_MIN_MATCHES   = 6'd2;
   localparam logic [15:0] RST_UPDATE_RATE   = 16'd16;
   localparam logic [15:0] RST_SPREAD_RATE   = 16'd8;
   localparam logic [4:0]  RST_INITIAL_SLOTS = 5'd10;
   localparam logic [5:0]  RST_SLOT_LIMIT    = 6'd20;
   localparam logic [7:0]  RST_FRAME_WIDTH   = 8'd128;
   localparam logic [7:0]  RST_FRAME_HEIGHT  = 8'd128;

   localparam logic [1:0] OFS_DOWN = 2'd0;
   localparam logic [1:0] OFS_UP   = 2'd2;

   // x mod 3 through a reciprocal multiply, exact for 16-bit x
   function automatic logic [1:0] mod3(input logic [RAND_W-1:0] x);
      logic [2*RAND_W:0] prod;
      logic [RAND_W-1:0] quo;
      logic [RAND_W+1:0] three_q;
      logic [RAND_W+1:0] diff;
      prod    = (2*RAND_W+1)'(x) * (2*RAND_W+1)'(17'd43691);
      quo     = prod[2*RAND_W:RAND_W+1];
      three_q = (RAND_W+2)'(quo) + ((RAND_W+2)'(quo) << 1);
      diff    = (RAND_W+2)'(x) - three_q;
      return diff[1:0];
   endfunction

endpackage

@@ rtl/core/sbs_stream_if.sv @@
// request and response channel interfaces of the background subtractor
// depends on sbs_pkg
`timescale 1ns / 1ps

interface sbs_req_if;
   import sbs_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_col;
   logic [COORD_W-1:0] pixel_row;
   logic [PIX_W-1:0]   pixel_value;
   logic [PIX_W-1:0]   neighbour_value;
   logic               end_of_frame;
   logic [RAND_W-1:0]  rand_self_gate;
   logic [RAND_W-1:0]  rand_self_slot;
   logic [RAND_W-1:0]  rand_spread_gate;
   logic [RAND_W-1:0]  rand_spread_dx;
   logic [RAND_W-1:0]  rand_spread_dy;
   logic [RAND_W-1:0]  rand_spread_slot;

   modport source (output valid, pixel_col, pixel_row, pixel_value, neighbour_value,
                   end_of_frame, rand_self_gate, rand_self_slot, rand_spread_gate,
                   rand_spread_dx, rand_spread_dy, rand_spread_slot, input ready);
   modport sink (input valid, pixel_col, pixel_row, pixel_value, neighbour_value,
                 end_of_frame, rand_self_gate, rand_self_slot, rand_spread_gate,
                 rand_spread_dx, rand_spread_dy, rand_spread_slot, output ready);
endinterface

interface sbs_rsp_if;
   import sbs_pkg::*;
   logic               valid;
   logic               ready;
   logic               foreground;
   logic [COORD_W-1:0] out_col;
   logic [COORD_W-1:0] out_row;

   modport source (output valid, foreground, out_col, out_row, input ready);
   modport sink (input valid, foreground, out_col, out_row, output ready);
endinterface

@@ rtl/core/sbs_mod_unit.sv @@
// multi-cycle remainder unit, radix-16 restoring, four bits a cycle
// depends on sbs_pkg
`timescale 1ns / 1ps

module sbs_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sbs_pkg::RAND_W-1:0] dividend,
   input  logic [sbs_pkg::RAND_W-1:0] divisor,
   output logic                      done,
   output logic [sbs_pkg::RAND_W-1:0] remainder
);
   import sbs_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [RAND_W-1:0]    num_ff, num_in;
   logic [RAND_W-1:0]    rem_ff, rem_in;
   logic [RAND_W-1:0]    div_ff;

   always_comb begin
      logic [RAND_W:0]   r;
      logic [RAND_W-1:0] q;
      r = {1'b0, rem_ff};
      q = num_ff;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r = {r[RAND_W-1:0], q[RAND_W-1]};
         q = q << 1;
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
      end
      rem_in = r[RAND_W-1:0];
      num_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(DIV_CYCLES);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

@@ rtl/core/sbs_sample_mem.sv @@
// sample store: one word per pixel holding every slot, per-slot write enables,
// registered read; depends on sbs_pkg
`timescale 1ns / 1ps

module sbs_sample_mem #(
   parameter int WORDS = 16384,
   parameter int SLOTS = 32,
   parameter int AW    = 14
) (
   input  logic                                clock,
   input  logic [AW-1:0]                       addr,
   input  logic                                rd_en,
   input  logic                                wr_en,
   input  logic [SLOTS-1:0]                    wr_mask,
   input  logic [SLOTS-1:0][sbs_pkg::PIX_W-1:0] wr_data,
   output logic [SLOTS-1:0][sbs_pkg::PIX_W-1:0] rd_data
);
   import sbs_pkg::*;

   logic [SLOTS-1:0][PIX_W-1:0] mem [WORDS];
   logic [SLOTS-1:0][PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS; s++) begin
         if (wr_en && wr_mask[s]) begin
            mem[addr][s] <= wr_data[s];
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sample_based_background_subtractor.sv @@
// top level of the sample-based background subtractor: control sequencer,
// registers, remainder units and sample store; depends on sbs_pkg,
// sbs_stream_if, sbs_mod_unit, sbs_sample_mem
//
//   channel   dir  handshake          carries
//   req_if    in   valid / ready      pixel, position, fill value, random words
//   rsp_if    out  valid / ready      foreground flag and echoed position
//   csr_*     in   csr_write_en       register index and write data
//
// each pixel passes through address, store read, match, count, wait for
// the four remainder units (each retiring four bits per step), then three
// ordered store writes (own slot, neighbour slot, growth slot) and hand-off.
// the single store port sets the write part; the remainder units set the wait.
// reset is synchronous; the store itself is not cleared, the first frame fills it.
// a stalled response holds the sequencer in its last state; no new request is
// taken until the previous one has been handed to the response register.
`timescale 1ns / 1ps

module sample_based_background_subtractor #(
   parameter int MAX_SLOTS  = 32,
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   sbs_req_if.sink                        req_if,
   sbs_rsp_if.source                      rsp_if,
   input  logic                           csr_write_en,
   input  logic [sbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbs_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sbs_pkg::*;

   localparam int SI    = $clog2(MAX_SLOTS);
   localparam int SW    = $clog2(MAX_SLOTS + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(WORDS);
   localparam logic [MAX_SLOTS-1:0] ONE_MASK = MAX_SLOTS'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_ADDR, S_READ, S_MATCH, S_COUNT, S_WAIT,
      S_WR_SELF, S_WR_SPREAD, S_WR_GROW, S_DONE
   } state_type;

   // registers
   logic [7:0]  radius_ff;
   logic [5:0]  min_ff;
   logic [15:0] urate_ff, srate_ff;
   logic [4:0]  init_ff;
   logic [5:0]  limit_ff;
   logic [7:0]  fwidth_ff, fheight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RST_MATCH_RADIUS;
         min_ff     <= RST_MIN_MATCHES;
         urate_ff   <= RST_UPDATE_RATE;
         srate_ff   <= RST_SPREAD_RATE;
         init_ff    <= RST_INITIAL_SLOTS;
         limit_ff   <= RST_SLOT_LIMIT;
         fwidth_ff  <= RST_FRAME_WIDTH;
         fheight_ff <= RST_FRAME_HEIGHT;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_MATCH_RADIUS:  radius_ff  <= csr_write_data[7:0];
            REG_MIN_MATCHES:   min_ff     <= csr_write_data[5:0];
            REG_UPDATE_RATE:   urate_ff   <= csr_write_data;
            REG_SPREAD_RATE:   srate_ff   <= csr_write_data;
            REG_INITIAL_SLOTS: init_ff    <= csr_write_data[4:0];
            REG_SLOT_LIMIT:    limit_ff   <= csr_write_data[5:0];
            REG_FRAME_WIDTH:   fwidth_ff  <= csr_write_data[7:0];
            REG_FRAME_HEIGHT:  fheight_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // effective limits
   logic [CW-1:0]     wlast;
   logic [RW-1:0]     hlast;
   logic [SW-1:0]     limit_eff, init_last;
   logic [RAND_W-1:0] urate_eff, srate_eff;

   always_comb begin
      if (fwidth_ff == '0) begin
         wlast = '0;
      end else if (CRD_W'(fwidth_ff) > CRD_W'(MAX_WIDTH)) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(CRD_W'(fwidth_ff) - 1'b1);
      end
      if (fheight_ff == '0) begin
         hlast = '0;
      end else if (CRD_W'(fheight_ff) > CRD_W'(MAX_HEIGHT)) begin
         hlast = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast = RW'(CRD_W'(fheight_ff) - 1'b1);
      end
      if (limit_ff == '0) begin
         limit_eff = SW'(1);
      end else if (CRD_W'(limit_ff) > CRD_W'(MAX_SLOTS)) begin
         limit_eff = SW'(MAX_SLOTS);
      end else begin
         limit_eff = SW'(limit_ff);
      end
      if (CRD_W'(init_ff) < CRD_W'(limit_eff)) begin
         init_last = SW'(init_ff);
      end else begin
         init_last = limit_eff - 1'b1;
      end
      urate_eff = (urate_ff == '0) ? RAND_W'(1) : urate_ff;
      srate_eff = (srate_ff == '0) ? RAND_W'(1) : srate_ff;
   end

   // item registers and model state
   state_type         state_ff;
   logic              model_ready_ff;
   logic [SW-1:0]     siu_ff;
   logic [COORD_W-1:0] col_in_ff, row_in_ff;
   logic [PIX_W-1:0]  pix_ff, nval_ff;
   logic              eof_ff;
   logic [RAND_W-1:0] g_self_ff, s_self_ff, g_spr_ff, dx_ff, dy_ff, s_spr_ff;
   logic [CW-1:0]     col_ff, ncol_ff;
   logic [RW-1:0]     row_ff, nrow_ff;
   logic [AW-1:0]     own_addr_ff, nbr_addr_ff;
   logic [MAX_SLOTS-1:0] match_ff;
   logic              bg_ff;
   logic              rsp_valid_ff, fg_out_ff;
   logic [COORD_W-1:0] out_col_ff, out_row_ff;

   logic [SW-1:0]     n_used;
   logic [CW-1:0]     col_cl, ncol_in;
   logic [RW-1:0]     row_cl, nrow_in;
   logic [1:0]        dx_m3, dy_m3;

   assign n_used = (siu_ff == '0) ? SW'(1) : siu_ff;
   assign dx_m3  = mod3(dx_ff);
   assign dy_m3  = mod3(dy_ff);

   always_comb begin
      col_cl = (CRD_W'(col_in_ff) > CRD_W'(wlast)) ? wlast : CW'(col_in_ff);
      row_cl = (CRD_W'(row_in_ff) > CRD_W'(hlast)) ? hlast : RW'(row_in_ff);
      case (dx_m3)
         OFS_DOWN: ncol_in = (col_ff == '0) ? '0 : col_ff - 1'b1;
         OFS_UP:   ncol_in = (col_ff >= wlast) ? wlast : col_ff + 1'b1;
         default:  ncol_in = col_ff;
      endcase
      case (dy_m3)
         OFS_DOWN: nrow_in = (row_ff == '0) ? '0 : row_ff - 1'b1;
         OFS_UP:   nrow_in = (row_ff >= hlast) ? hlast : row_ff + 1'b1;
         default:  nrow_in = row_ff;
      endcase
   end

   // remainder units
   logic              div_start;
   logic [3:0]        div_done;
   logic [RAND_W-1:0] rem_g_self, rem_s_self, rem_g_spr, rem_s_spr;

   assign div_start = (state_ff == S_READ);

   sbs_mod_unit u_mod_gself (
      .clock(clock), .reset(reset), .start(div_start), .dividend(g_self_ff),
      .divisor(urate_eff), .done(div_done[0]), .remainder(rem_g_self));
   sbs_mod_unit u_mod_sself (
      .clock(clock), .reset(reset), .start(div_start), .dividend(s_self_ff),
      .divisor(RAND_W'(n_used)), .done(div_done[1]), .remainder(rem_s_self));
   sbs_mod_unit u_mod_gspr (
      .clock(clock), .reset(reset), .start(div_start), .dividend(g_spr_ff),
      .divisor(srate_eff), .done(div_done[2]), .remainder(rem_g_spr));
   sbs_mod_unit u_mod_sspr (
      .clock(clock), .reset(reset), .start(div_start), .dividend(s_spr_ff),
      .divisor(RAND_W'(n_used)), .done(div_done[3]), .remainder(rem_s_spr));

   // sample store
   logic [AW-1:0]                   mem_addr;
   logic                            mem_rd, mem_wr;
   logic [MAX_SLOTS-1:0]            mem_mask;
   logic [MAX_SLOTS-1:0][PIX_W-1:0] mem_wdata, mem_rdata;
   logic [MAX_SLOTS-1:0]            match_in, fill_mask;
   logic                            grow_ok;

   assign grow_ok = (siu_ff < limit_eff);

   always_comb begin
      logic [PIX_W-1:0] d;
      for (int s = 0; s < MAX_SLOTS; s++) begin
         d = (mem_rdata[s] > pix_ff) ? mem_rdata[s] - pix_ff : pix_ff - mem_rdata[s];
         match_in[s]  = (SW'(s) < n_used) && (d < radius_ff);
         fill_mask[s] = (SW'(s) <= init_last);
      end
   end

   always_comb begin
      mem_addr  = own_addr_ff;
      mem_rd    = 1'b0;
      mem_wr    = 1'b0;
      mem_mask  = '0;
      mem_wdata = {MAX_SLOTS{pix_ff}};
      case (state_ff)
         S_READ: mem_rd = 1'b1;
         S_WR_SELF: begin
            mem_wr = 1'b1;
            if (!model_ready_ff) begin
               mem_mask  = fill_mask;
               mem_wdata = {MAX_SLOTS{nval_ff}};
            end else if (bg_ff && (rem_g_self == '0)) begin
               mem_mask = ONE_MASK << rem_s_self[SI-1:0];
            end
         end
         S_WR_SPREAD: begin
            mem_wr   = 1'b1;
            mem_addr = nbr_addr_ff;
            if (model_ready_ff && bg_ff && (rem_g_spr == '0)) begin
               mem_mask = ONE_MASK << rem_s_spr[SI-1:0];
            end
         end
         S_WR_GROW: begin
            mem_wr    = 1'b1;
            mem_wdata = {MAX_SLOTS{nval_ff}};
            if (model_ready_ff && grow_ok) begin
               mem_mask = ONE_MASK << siu_ff[SI-1:0];
            end
         end
         default: ;
      endcase
   end

   sbs_sample_mem #(.WORDS(WORDS), .SLOTS(MAX_SLOTS), .AW(AW)) u_store (
      .clock(clock), .addr(mem_addr), .rd_en(mem_rd), .wr_en(mem_wr),
      .wr_mask(mem_mask), .wr_data(mem_wdata), .rd_data(mem_rdata));

   logic req_fire;
   assign req_fire = req_if.valid && req_if.ready;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         model_ready_ff <= 1'b0;
         siu_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR:  state_ff <= S_READ;
            S_READ:  state_ff <= S_MATCH;
            S_MATCH: state_ff <= S_COUNT;
            S_COUNT: state_ff <= S_WAIT;
            S_WAIT: begin
               if (&div_done) begin
                  state_ff <= S_WR_SELF;
               end
            end
            S_WR_SELF:   state_ff <= S_WR_SPREAD;
            S_WR_SPREAD: state_ff <= S_WR_GROW;
            S_WR_GROW: begin
               state_ff <= S_DONE;
               if (!model_ready_ff) begin
                  if (eof_ff) begin
                     model_ready_ff <= 1'b1;
                     siu_ff         <= init_last + 1'b1;
                  end
               end else if (grow_ok && eof_ff) begin
                  siu_ff <= siu_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         col_in_ff <= req_if.pixel_col;
         row_in_ff <= req_if.pixel_row;
         pix_ff    <= req_if.pixel_value;
         nval_ff   <= req_if.neighbour_value;
         eof_ff    <= req_if.end_of_frame;
         g_self_ff <= req_if.rand_self_gate;
         s_self_ff <= req_if.rand_self_slot;
         g_spr_ff  <= req_if.rand_spread_gate;
         dx_ff     <= req_if.rand_spread_dx;
         dy_ff     <= req_if.rand_spread_dy;
         s_spr_ff  <= req_if.rand_spread_slot;
      end
      if (state_ff == S_ADDR) begin
         col_ff      <= col_cl;
         row_ff      <= row_cl;
         own_addr_ff <= AW'(row_cl) * AW'(MAX_WIDTH) + AW'(col_cl);
      end
      if (state_ff == S_READ) begin
         ncol_ff <= ncol_in;
         nrow_ff <= nrow_in;
      end
      if (state_ff == S_MATCH) begin
         match_ff    <= match_in;
         nbr_addr_ff <= AW'(nrow_ff) * AW'(MAX_WIDTH) + AW'(ncol_ff);
      end
      if (state_ff == S_COUNT) begin
         bg_ff <= model_ready_ff &&
                  (CRD_W'($countones(match_ff)) >= CRD_W'(min_ff));
      end
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready)) begin
         fg_out_ff  <= !bg_ff;
         out_col_ff <= col_in_ff;
         out_row_ff <= row_in_ff;
      end
   end

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.foreground = fg_out_ff;
   assign rsp_if.out_col    = out_col_ff;
   assign rsp_if.out_row    = out_row_ff;

`ifndef SYNTHESIS
   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      siu_ff <= SW'(MAX_SLOTS))
      else $error("slot count beyond store width");

   a_write_after_rem: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> (&div_done))
      else $error("store written before remainders settled");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_ADDR))
      else $error("accepted request did not start the sequence");

   a_ready_on_eof: assert property (@(posedge clock) disable iff (reset)
      $rose(model_ready_ff) |-> ($past(eof_ff) && ($past(state_ff) == S_WR_GROW)))
      else $error("model became ready without end of frame");
`endif

endmodule
